// ===== design/mkd_pkg.sv =====
// shared types and constants for the matrix keypad debounce block
// no dependencies; used by every other design file
package mkd_pkg;

   localparam int KEY_W       = 8;
   localparam int MATRIX_W    = 16;
   localparam int TIME_W      = 32;
   localparam int DEBOUNCE_W  = 16;
   localparam int KEYMAP_W    = KEY_W * MATRIX_W;
   localparam int CSR_DATA_W  = 64;
   localparam int CSR_ADDR_W  = 5;
   localparam int QUEUE_DEPTH = 2;
   localparam int QUEUE_PTR_W = 1;
   localparam int QUEUE_CNT_W = 2;

   localparam logic [DEBOUNCE_W-1:0] DEBOUNCE_RESET = 16'd30;
   localparam logic [KEY_W-1:0]      NO_KEY_RESET   = 8'h00;

   // register index, taken from paddr[4:3]
   typedef enum logic [1:0] {
      REG_DEBOUNCE_TIME = 2'd0,
      REG_KEYMAP_LO     = 2'd1,
      REG_KEYMAP_HI     = 2'd2,
      REG_NO_KEY_CODE   = 2'd3
   } mkd_reg_type;

   typedef struct packed {
      logic [DEBOUNCE_W-1:0] debounce_time;
      logic [KEYMAP_W-1:0]   keymap;        // byte n is position n
      logic [KEY_W-1:0]      no_key_code;
   } mkd_cfg_type;

   typedef struct packed {
      logic [KEY_W-1:0]  raw_code;
      logic [TIME_W-1:0] now_ms;
   } mkd_entry_type;

   typedef struct packed {
      logic full;
      logic empty;
   } mkd_queue_status_type;

endpackage

// ===== design/mkd_req_if.sv =====
// poll channel: sampled key matrix and timestamp
// depends on mkd_pkg
interface mkd_req_if;
   logic                            valid;
   logic                            ready;
   logic [mkd_pkg::MATRIX_W-1:0]    pressed_matrix;
   logic [mkd_pkg::TIME_W-1:0]      now_ms;

   modport source (output valid, output pressed_matrix, output now_ms, input ready);
   modport sink   (input valid, input pressed_matrix, input now_ms, output ready);
endinterface

// ===== design/mkd_rsp_if.sv =====
// result channel: key event flag and key code
// depends on mkd_pkg
interface mkd_rsp_if;
   logic                         valid;
   logic                         ready;
   logic                         key_event;
   logic [mkd_pkg::KEY_W-1:0]    key_code;

   modport source (output valid, output key_event, output key_code, input ready);
   modport sink   (input valid, input key_event, input key_code, output ready);
endinterface

// ===== design/matrix_keypad_debounce.sv =====
// matrix keypad scanner with debounce, top level
// a poll accepted into the queue is written there first, then the
// debounce update carries it into the output register
// throughput: one poll per cycle unless the output stalls, set by the debounce update
// reset is synchronous: state returns to the no-key code, queue and output
// stage empty, registers to debounce 30 ms, keymap zero, no-key code zero
module matrix_keypad_debounce #(
   parameter int ROWS = 4,
   parameter int COLS = 4
) (
   input  logic                              clock,
   input  logic                              reset,
   mkd_req_if.sink                           req,
   mkd_rsp_if.source                         rsp,
   input  logic                              csr_psel,
   input  logic                              csr_penable,
   input  logic                              csr_pwrite,
   input  logic [mkd_pkg::CSR_ADDR_W-1:0]    csr_paddr,
   input  logic [mkd_pkg::CSR_DATA_W-1:0]    csr_pwdata,
   output logic [mkd_pkg::CSR_DATA_W-1:0]    csr_prdata,
   output logic                              csr_pready
);

   // configuration; the user keeps it static while transactions are in flight, the block has no check for it
   mkd_pkg::mkd_cfg_type          cfg;
   // queue hookup between the front and back halves
   mkd_pkg::mkd_queue_status_type queue_status;
   mkd_pkg::mkd_entry_type        push_entry;
   mkd_pkg::mkd_entry_type        head;
   logic                          push;
   logic                          pop;

   // register file, 8-byte stride per register
   mkd_csr u_csr (
      .clock   (clock),
      .reset   (reset),
      .psel    (csr_psel),
      .penable (csr_penable),
      .pwrite  (csr_pwrite),
      .paddr   (csr_paddr),
      .pwdata  (csr_pwdata),
      .prdata  (csr_prdata),
      .pready  (csr_pready),
      .cfg     (cfg)
   );

   // front: first pressed grid position, mapped through the keymap
   mkd_front #(
      .ROWS (ROWS),
      .COLS (COLS)
   ) u_front (
      .req          (req),
      .cfg          (cfg),
      .queue_status (queue_status),
      .push         (push),
      .push_entry   (push_entry)
   );

   // two entries absorb polls while the output stalls; the sender is held once both are full
   mkd_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push       (push),
      .push_entry (push_entry),
      .pop        (pop),
      .head       (head),
      .status     (queue_status)
   );

   // back: hold timer, settled and announced key, output register
   mkd_back u_back (
      .clock        (clock),
      .reset        (reset),
      .cfg          (cfg),
      .head         (head),
      .queue_status (queue_status),
      .pop          (pop),
      .rsp          (rsp)
   );

endmodule

// ===== design/mkd_csr.sv =====
// apb-style register file for debounce time, keymap and no-key code
// depends on mkd_pkg
module mkd_csr (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              psel,
   input  logic                              penable,
   input  logic                              pwrite,
   input  logic [mkd_pkg::CSR_ADDR_W-1:0]    paddr,
   input  logic [mkd_pkg::CSR_DATA_W-1:0]    pwdata,
   output logic [mkd_pkg::CSR_DATA_W-1:0]    prdata,
   output logic                              pready,
   output mkd_pkg::mkd_cfg_type              cfg
);

   mkd_pkg::mkd_cfg_type cfg_ff;
   mkd_pkg::mkd_cfg_type cfg_in;
   mkd_pkg::mkd_reg_type reg_sel;
   logic                 wr_en;

   assign reg_sel = mkd_pkg::mkd_reg_type'(paddr[4:3]);
   assign wr_en   = psel & penable & pwrite;
   assign pready  = 1'b1;
   assign cfg     = cfg_ff;

   always_comb begin
      cfg_in = cfg_ff;
      if (wr_en) begin
         unique case (reg_sel)
            mkd_pkg::REG_DEBOUNCE_TIME: begin
               cfg_in.debounce_time = pwdata[mkd_pkg::DEBOUNCE_W-1:0];
            end
            mkd_pkg::REG_KEYMAP_LO: begin
               cfg_in.keymap[63:0] = pwdata;
            end
            mkd_pkg::REG_KEYMAP_HI: begin
               cfg_in.keymap[127:64] = pwdata;
            end
            mkd_pkg::REG_NO_KEY_CODE: begin
               cfg_in.no_key_code = pwdata[mkd_pkg::KEY_W-1:0];
            end
         endcase
      end
   end

   always_comb begin
      prdata = '0;
      unique case (reg_sel)
         mkd_pkg::REG_DEBOUNCE_TIME: begin
            prdata = {48'd0, cfg_ff.debounce_time};
         end
         mkd_pkg::REG_KEYMAP_LO: begin
            prdata = cfg_ff.keymap[63:0];
         end
         mkd_pkg::REG_KEYMAP_HI: begin
            prdata = cfg_ff.keymap[127:64];
         end
         mkd_pkg::REG_NO_KEY_CODE: begin
            prdata = {56'd0, cfg_ff.no_key_code};
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.debounce_time <= mkd_pkg::DEBOUNCE_RESET;
         cfg_ff.keymap        <= '0;
         cfg_ff.no_key_code   <= mkd_pkg::NO_KEY_RESET;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

endmodule

// ===== design/mkd_front.sv =====
// front end: accepts polls, picks the first pressed key and maps it
// depends on mkd_pkg and mkd_req_if
module mkd_front #(
   parameter int ROWS = 4,
   parameter int COLS = 4
) (
   mkd_req_if.sink                      req,
   input  mkd_pkg::mkd_cfg_type         cfg,
   input  mkd_pkg::mkd_queue_status_type queue_status,
   output logic                         push,
   output mkd_pkg::mkd_entry_type       push_entry
);

   function automatic logic [mkd_pkg::MATRIX_W-1:0] grid_mask_f();
      logic [mkd_pkg::MATRIX_W-1:0] mask;
      mask = '0;
      for (int r = 0; r < ROWS; r++) begin
         for (int c = 0; c < COLS; c++) begin
            mask[(r * COLS + c) % mkd_pkg::MATRIX_W] = 1'b1;
         end
      end
      return mask;
   endfunction

   localparam logic [mkd_pkg::MATRIX_W-1:0] GRID_MASK = grid_mask_f();

   logic [mkd_pkg::MATRIX_W-1:0] hits;
   logic [mkd_pkg::KEY_W-1:0]    raw_code;
   logic                         found;

   assign hits      = req.pressed_matrix & GRID_MASK;
   assign req.ready = ~queue_status.full;
   assign push      = req.valid & ~queue_status.full;

   // lowest set position wins (row-major order)
   always_comb begin
      raw_code = cfg.no_key_code;
      found    = 1'b0;
      for (int p = 0; p < mkd_pkg::MATRIX_W; p++) begin
         if (!found && hits[p]) begin
            found    = 1'b1;
            raw_code = cfg.keymap[p * mkd_pkg::KEY_W +: mkd_pkg::KEY_W];
         end
      end
   end

   assign push_entry.raw_code = raw_code;
   assign push_entry.now_ms   = req.now_ms;

endmodule

// ===== design/mkd_queue.sv =====
// two-entry queue between the front end and the debounce back end
// depends on mkd_pkg
module mkd_queue (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           push,
   input  mkd_pkg::mkd_entry_type         push_entry,
   input  logic                           pop,
   output mkd_pkg::mkd_entry_type         head,
   output mkd_pkg::mkd_queue_status_type  status
);

   mkd_pkg::mkd_entry_type              slot_ff [mkd_pkg::QUEUE_DEPTH];
   logic [mkd_pkg::QUEUE_PTR_W-1:0]     wr_ptr_ff;
   logic [mkd_pkg::QUEUE_PTR_W-1:0]     wr_ptr_in;
   logic [mkd_pkg::QUEUE_PTR_W-1:0]     rd_ptr_ff;
   logic [mkd_pkg::QUEUE_PTR_W-1:0]     rd_ptr_in;
   logic [mkd_pkg::QUEUE_CNT_W-1:0]     count_ff;
   logic [mkd_pkg::QUEUE_CNT_W-1:0]     count_in;

   assign head         = slot_ff[rd_ptr_ff];
   assign status.full  = (count_ff == mkd_pkg::QUEUE_CNT_W'(mkd_pkg::QUEUE_DEPTH));
   assign status.empty = (count_ff == '0);

   always_comb begin
      wr_ptr_in = push ? wr_ptr_ff + 1'b1 : wr_ptr_ff;
      rd_ptr_in = pop  ? rd_ptr_ff + 1'b1 : rd_ptr_ff;
      count_in  = count_ff;
      if (push && !pop) begin
         count_in = count_ff + 1'b1;
      end else if (pop && !push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         slot_ff[wr_ptr_ff] <= push_entry;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= mkd_pkg::QUEUE_CNT_W'(mkd_pkg::QUEUE_DEPTH))
      else $error("queue count above depth");

   a_no_underflow: assert property (@(posedge clock) disable iff (reset)
      pop |-> count_ff != '0)
      else $error("queue popped while empty");

endmodule

// ===== design/mkd_back.sv =====
// back end: debounce state update and registered result stage
// depends on mkd_pkg and mkd_rsp_if
module mkd_back (
   input  logic                           clock,
   input  logic                           reset,
   input  mkd_pkg::mkd_cfg_type           cfg,
   input  mkd_pkg::mkd_entry_type         head,
   input  mkd_pkg::mkd_queue_status_type  queue_status,
   output logic                           pop,
   mkd_rsp_if.source                      rsp
);

   logic [mkd_pkg::KEY_W-1:0]  prev_raw_ff,  prev_raw_in;
   logic [mkd_pkg::KEY_W-1:0]  settled_ff,   settled_in;
   logic [mkd_pkg::KEY_W-1:0]  announced_ff, announced_in;
   logic [mkd_pkg::TIME_W-1:0] change_ff,    change_in;
   logic                       rsp_valid_ff, rsp_valid_in;
   logic                       rsp_event_ff, rsp_event_in;
   logic [mkd_pkg::KEY_W-1:0]  rsp_code_ff,  rsp_code_in;
   logic [mkd_pkg::TIME_W-1:0] elapsed;
   logic                       held_long;
   logic                       key_event;

   assign pop       = ~queue_status.empty & (~rsp_valid_ff | rsp.ready);
   assign elapsed   = head.now_ms - change_ff;
   assign held_long = elapsed >= {16'd0, cfg.debounce_time};

   always_comb begin
      prev_raw_in  = prev_raw_ff;
      settled_in   = settled_ff;
      announced_in = announced_ff;
      change_in    = change_ff;
      key_event    = 1'b0;
      if (pop) begin
         if (head.raw_code != prev_raw_ff) begin
            // raw code moved, restart the hold timer
            prev_raw_in = head.raw_code;
            change_in   = head.now_ms;
         end else if (held_long && (head.raw_code != settled_ff)) begin
            settled_in = head.raw_code;
            if (head.raw_code == cfg.no_key_code) begin
               announced_in = cfg.no_key_code;
            end else if (head.raw_code != announced_ff) begin
               announced_in = head.raw_code;
               key_event    = 1'b1;
            end
         end
      end
      rsp_event_in = key_event;
      rsp_code_in  = key_event ? head.raw_code : cfg.no_key_code;
      priority if (pop) begin
         rsp_valid_in = 1'b1;
      end else if (rsp.ready) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (pop) begin
         rsp_event_ff <= rsp_event_in;
         rsp_code_ff  <= rsp_code_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         prev_raw_ff  <= mkd_pkg::NO_KEY_RESET;
         settled_ff   <= mkd_pkg::NO_KEY_RESET;
         announced_ff <= mkd_pkg::NO_KEY_RESET;
         change_ff    <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         prev_raw_ff  <= prev_raw_in;
         settled_ff   <= settled_in;
         announced_ff <= announced_in;
         change_ff    <= change_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign rsp.valid     = rsp_valid_ff;
   assign rsp.key_event = rsp_event_ff;
   assign rsp.key_code  = rsp_code_ff;

   a_pop_fills_output: assert property (@(posedge clock) disable iff (reset)
      pop |=> rsp_valid_ff)
      else $error("popped transaction did not reach the output stage");

   a_event_matches_announced: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && rsp_event_ff) |-> (rsp_code_ff == announced_ff))
      else $error("event code differs from announced key");

endmodule

// ===== sim/keypad_check_pkg.sv =====
// keypad debounce checker: expected-report predictor and result comparison
// depends on mkd_pkg for the register index type and field widths
package keypad_check_pkg;
   import mkd_pkg::*;

   localparam int KEY_ROWS = 4;
   localparam int KEY_COLS = 4;

   typedef struct packed {
      logic             key_event;
      logic [KEY_W-1:0] key_code;
   } key_report_type;

   class keypad_report_board;
      logic [DEBOUNCE_W-1:0] hold_ms;
      logic [KEYMAP_W-1:0]   code_map;
      logic [KEY_W-1:0]      idle_code;
      logic [KEY_W-1:0]      last_raw;
      logic [KEY_W-1:0]      steady_key;
      logic [KEY_W-1:0]      shown_key;
      logic [TIME_W-1:0]     raw_since;
      key_report_type        expected_reports[$];
      int                    mismatches;

      function new();
         hold_ms      = DEBOUNCE_RESET;
         code_map     = '0;
         idle_code    = NO_KEY_RESET;
         last_raw     = NO_KEY_RESET;
         steady_key   = NO_KEY_RESET;
         shown_key    = NO_KEY_RESET;
         raw_since    = '0;
         mismatches   = 0;
      endfunction

      function void write_reg(mkd_reg_type idx, logic [CSR_DATA_W-1:0] value);
         case (idx)
            REG_DEBOUNCE_TIME: hold_ms = value[DEBOUNCE_W-1:0];
            REG_KEYMAP_LO:     code_map[63:0] = value;
            REG_KEYMAP_HI:     code_map[127:64] = value;
            default:           idle_code = value[KEY_W-1:0];
         endcase
      endfunction

      // first pressed grid position in row-major order, through the keymap
      function logic [KEY_W-1:0] scan_code(logic [MATRIX_W-1:0] matrix);
         int pos;
         for (int r = 0; r < KEY_ROWS; r++) begin
            for (int c = 0; c < KEY_COLS; c++) begin
               pos = (r * KEY_COLS + c) & 15;
               if (matrix[pos]) return code_map[pos*KEY_W +: KEY_W];
            end
         end
         return idle_code;
      endfunction

      function void note_poll(logic [MATRIX_W-1:0] matrix, logic [TIME_W-1:0] now_ms);
         logic [KEY_W-1:0]  raw;
         logic [TIME_W-1:0] held;
         key_report_type    report;
         raw  = scan_code(matrix);
         held = now_ms - raw_since;
         report.key_event = 1'b0;
         if (raw != last_raw) begin
            last_raw  = raw;
            raw_since = now_ms;
         end else if (held >= {16'd0, hold_ms}) begin
            if (raw != steady_key) begin
               steady_key = raw;
               if (raw == idle_code) begin
                  shown_key = idle_code;
               end else if (raw != shown_key) begin
                  shown_key        = raw;
                  report.key_event = 1'b1;
               end
            end
         end
         report.key_code = report.key_event ? raw : idle_code;
         expected_reports.push_back(report);
      endfunction

      function void check_report(logic key_event, logic [KEY_W-1:0] key_code,
                                 longint unsigned stamp_ns);
         key_report_type want;
         if (expected_reports.size() == 0) begin
            $display("%0d ns: unexpected transaction key_event=%0b key_code=0x%02h",
                     stamp_ns, key_event, key_code);
            mismatches++;
            return;
         end
         want = expected_reports.pop_front();
         if (key_event !== want.key_event) begin
            $display("%0d ns: key_event expected %0b actual %0b",
                     stamp_ns, want.key_event, key_event);
            mismatches++;
         end
         if (key_code !== want.key_code) begin
            $display("%0d ns: key_code expected 0x%02h actual 0x%02h",
                     stamp_ns, want.key_code, key_code);
            mismatches++;
         end
      endfunction

      function int pending();
         return expected_reports.size();
      endfunction
   endclass

endpackage

// ===== sim/tb_top.sv =====
// testbench top for matrix_keypad_debounce: directed and random polls,
// bursty sender, stalling receiver, register writes between phases
// depends on mkd_pkg, the channel interfaces and keypad_check_pkg
module tb_top;
   timeunit 1ns;
   timeprecision 1ps;

   import mkd_pkg::*;
   import keypad_check_pkg::*;

   typedef enum int {RX_ALWAYS, RX_RANDOM, RX_PERIODIC, RX_BURSTY} rx_mode_type;

   logic clock;
   logic reset;
   logic                  csr_psel;
   logic                  csr_penable;
   logic                  csr_pwrite;
   logic [CSR_ADDR_W-1:0] csr_paddr;
   logic [CSR_DATA_W-1:0] csr_pwdata;
   logic [CSR_DATA_W-1:0] csr_prdata;
   logic                  csr_pready;

   mkd_req_if req_if();
   mkd_rsp_if rsp_if();

   keypad_report_board key_board = new();

   // sender bookkeeping
   int          burst_left;
   int          polls_sent;
   logic [31:0] key_ms;

   // receiver stall pattern
   rx_mode_type rx_mode;
   int          rx_cycle;
   int          rx_count;
   logic        rx_low;

   matrix_keypad_debounce #(
      .ROWS(KEY_ROWS),
      .COLS(KEY_COLS)
   ) u_dut (
      .clock      (clock),
      .reset      (reset),
      .req        (req_if),
      .rsp        (rsp_if),
      .csr_psel   (csr_psel),
      .csr_penable(csr_penable),
      .csr_pwrite (csr_pwrite),
      .csr_paddr  (csr_paddr),
      .csr_pwdata (csr_pwdata),
      .csr_prdata (csr_prdata),
      .csr_pready (csr_pready)
   );

   // 12 ns clock
   initial clock = 1'b0;
   always #6 clock = ~clock;

   // hard stop well beyond the slowest legal run
   initial begin
      #5000000;
      $display("Simulation FAILED");
      $finish;
   end

   // receiver: ready changes at the falling edge, the mode is periodically redrawn at random
   always @(negedge clock) begin
      rx_cycle++;
      if (rx_cycle % 128 == 0) rx_mode = rx_mode_type'($urandom_range(0, 3));
      case (rx_mode)
         RX_ALWAYS:   rsp_if.ready <= 1'b1;
         RX_RANDOM:   rsp_if.ready <= ($urandom_range(0, 2) != 0);
         RX_PERIODIC: rsp_if.ready <= ((rx_cycle % 7) > 1);
         default: begin
            // alternating runs of stall and accept, each of random length
            if (rx_count == 0) begin
               rx_low   = ~rx_low;
               rx_count = $urandom_range(1, 8);
            end
            rx_count--;
            rsp_if.ready <= ~rx_low;
         end
      endcase
   end

   // result monitor: compare every accepted result transaction
   always @(posedge clock) begin
      if (!reset && rsp_if.valid && rsp_if.ready)
         key_board.check_report(rsp_if.key_event, rsp_if.key_code, $time);
   end

   // apb write: setup cycle, then access cycle until pready
   task automatic write_csr(input mkd_reg_type idx, input logic [CSR_DATA_W-1:0] value);
      @(negedge clock);
      csr_psel    = 1'b1;
      csr_penable = 1'b0;
      csr_pwrite  = 1'b1;
      csr_paddr   = {idx, 3'b000};
      csr_pwdata  = value;
      @(negedge clock);
      csr_penable = 1'b1;
      @(posedge clock);
      while (!csr_pready) @(posedge clock);
      key_board.write_reg(idx, value);
      @(negedge clock);
      csr_psel    = 1'b0;
      csr_penable = 1'b0;
      csr_pwrite  = 1'b0;
   endtask

   task automatic set_config(input logic [15:0] hold, input logic [127:0] map,
                             input logic [7:0] idle);
      write_csr(REG_DEBOUNCE_TIME, {48'd0, hold});
      write_csr(REG_KEYMAP_LO, map[63:0]);
      write_csr(REG_KEYMAP_HI, map[127:64]);
      write_csr(REG_NO_KEY_CODE, {56'd0, idle});
   endtask

   // one poll transaction; bursts of random length with random gaps between
   task automatic send_poll(input logic [15:0] matrix, input logic [31:0] now_ms);
      int gap;
      if (burst_left == 0) begin
         burst_left = $urandom_range(1, 24);
         gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 5);
         repeat (gap) begin
            @(negedge clock);
            req_if.valid = 1'b0;
         end
      end
      burst_left--;
      @(negedge clock);
      req_if.valid          = 1'b1;
      req_if.pressed_matrix = matrix;
      req_if.now_ms         = now_ms;
      @(posedge clock);
      while (!req_if.ready) @(posedge clock);
      key_board.note_poll(matrix, now_ms);
      polls_sent++;
   endtask

   // same matrix held over several polls with the clock moving forward
   task automatic hold_key(input logic [15:0] matrix, input int polls, input int max_step);
      repeat (polls) begin
         send_poll(matrix, key_ms);
         key_ms += $urandom_range(0, max_step);
      end
   endtask

   // quiet point for register writes: all results in, then the bench idles before returning
   task automatic settle();
      @(negedge clock);
      req_if.valid = 1'b0;
      while (key_board.pending() != 0) @(posedge clock);
      repeat (4) @(posedge clock);
   endtask

   function automatic logic [15:0] pick_press();
      logic [15:0] m;
      case ($urandom_range(0, 3))
         0:       m = 16'd1 << $urandom_range(0, 15);
         1:       m = (16'd1 << $urandom_range(0, 15)) | (16'd1 << $urandom_range(0, 15));
         2:       m = 16'($urandom);
         default: m = 16'($urandom & (16'hFFFF << $urandom_range(8, 15)));
      endcase
      return m;
   endfunction

   // random keymap with some entries equal to the idle code and some duplicates
   function automatic logic [127:0] make_keymap(input logic [7:0] idle);
      logic [127:0] map;
      int           pick;
      for (int n = 0; n < 16; n++) begin
         pick = $urandom_range(0, 7);
         if (pick == 0)
            map[n*8 +: 8] = idle;
         else if (pick == 1 && n > 0)
            map[n*8 +: 8] = map[$urandom_range(0, n-1)*8 +: 8];
         else
            map[n*8 +: 8] = 8'($urandom);
      end
      return map;
   endfunction

   // mostly clean press/hold/release sequences, some bounce and noise
   task automatic random_phase(input int n_polls, input int max_step);
      int goal;
      goal = polls_sent + n_polls;
      while (polls_sent < goal) begin
         case ($urandom_range(0, 9))
            0, 1, 2, 3, 4, 5: begin
               // contact bounce, then a steady press
               repeat ($urandom_range(0, 3)) begin
                  send_poll(16'($urandom), key_ms);
                  key_ms += $urandom_range(0, 2);
               end
               hold_key(pick_press(), $urandom_range(1, 6), max_step);
            end
            6, 7: hold_key(16'h0000, $urandom_range(1, 5), max_step);
            8: begin
               // timestamp jump, exercises wraparound and upper bits
               key_ms = $urandom;
               hold_key(pick_press(), $urandom_range(1, 4), max_step);
            end
            default: begin
               send_poll(16'($urandom), key_ms);
               key_ms += $urandom_range(0, max_step);
            end
         endcase
      end
   endtask

   initial begin
      logic [15:0]  hold;
      logic [7:0]   idle;
      logic [127:0] map;

      reset                 = 1'b1;
      csr_psel              = 1'b0;
      csr_penable           = 1'b0;
      csr_pwrite            = 1'b0;
      csr_paddr             = '0;
      csr_pwdata            = '0;
      req_if.valid          = 1'b0;
      req_if.pressed_matrix = '0;
      req_if.now_ms         = '0;
      rsp_if.ready          = 1'b1;
      rx_mode               = RX_ALWAYS;
      rx_cycle              = 0;
      rx_count              = 0;
      rx_low                = 1'b0;
      burst_left            = 0;
      polls_sent            = 0;
      key_ms                = '0;

      repeat (10) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      // reset config: keymap all zero equals the idle code, nothing ever reports
      send_poll(16'hFFFF, 32'd0);
      send_poll(16'hFFFF, 32'd30);
      send_poll(16'h0001, 32'd31);
      send_poll(16'h0000, 32'd100);
      settle();

      // directed: 5 ms debounce, position 5 mapped to the idle code,
      // codes 0x00 and 0xFF present as real keys
      map = 128'h FF1E1D1C_1B1A1918_1716EE14_13121100;
      set_config(16'd5, map, 8'hEE);
      send_poll(16'h0000, 32'd100);        // raw moves to the new idle code
      send_poll(16'h0000, 32'd105);        // idle settles, no report
      send_poll(16'h0001, 32'd106);        // raw change
      send_poll(16'h0001, 32'd110);        // one ms short
      send_poll(16'h0001, 32'd111);        // settles, reports code 0x00
      send_poll(16'h0001, 32'd200);        // held, no second report
      send_poll(16'h8000, 32'd201);        // top corner
      send_poll(16'h8000, 32'd206);        // reports 0xFF
      send_poll(16'hFFFF, 32'd207);        // all pressed, lowest wins
      send_poll(16'hFFFF, 32'd212);
      send_poll(16'h0020, 32'd213);        // key mapped to the idle code
      send_poll(16'h0020, 32'd218);        // settles as a release
      send_poll(16'h0120, 32'd219);
      send_poll(16'h0002, 32'd220);        // bounce between two keys
      send_poll(16'h0004, 32'd221);
      send_poll(16'h0002, 32'd222);
      send_poll(16'h0002, 32'd227);
      send_poll(16'h0008, 32'hFFFF_FFFE);  // debounce across the 32-bit wrap
      send_poll(16'h0008, 32'h0000_0003);
      send_poll(16'h0000, 32'h0000_0010);  // release
      send_poll(16'h0000, 32'h0000_0015);
      send_poll(16'h0008, 32'h0000_0016);  // same key again reports again
      send_poll(16'h0008, 32'h0000_001B);
      settle();

      // zero debounce, idle code 0x00
      set_config(16'd0, make_keymap(8'h00), 8'h00);
      random_phase(250, 3);
      settle();

      // longest debounce, idle code 0xFF, big time steps
      set_config(16'hFFFF, make_keymap(8'hFF), 8'hFF);
      random_phase(200, 40000);
      settle();

      // short debounce, random idle code
      idle = 8'($urandom);
      set_config(16'($urandom_range(1, 20)), make_keymap(idle), idle);
      random_phase(300, 8);
      settle();

      // moderate debounce
      idle = 8'($urandom);
      set_config(16'($urandom_range(20, 200)), make_keymap(idle), idle);
      random_phase(250, 60);
      settle();

      // first half all ones equals the idle code, second half all zero
      set_config(16'd3, {64'h0, 64'hFFFF_FFFF_FFFF_FFFF}, 8'hFF);
      random_phase(200, 4);
      settle();

      // fully random debounce, idle code changed with keys still held
      hold = 16'($urandom);
      idle = 8'($urandom);
      set_config(hold, make_keymap(idle), idle);
      random_phase(250, int'(hold) / 3 + 1);
      settle();

      repeat (8) @(posedge clock);
      if (key_board.mismatches == 0 && key_board.pending() == 0) begin
         $display("Simulation PASSED");
      end else begin
         $display("Simulation FAILED");
      end
      $finish;
   end

endmodule

// ===== filelist.f =====
design/mkd_pkg.sv
design/mkd_req_if.sv
design/mkd_rsp_if.sv
design/mkd_csr.sv
design/mkd_front.sv
design/mkd_queue.sv
design/mkd_back.sv
design/matrix_keypad_debounce.sv
sim/keypad_check_pkg.sv
sim/tb_top.sv
